// ===== rtl/core/trfr_pkg.sv =====
// Shared types and constants for the ring frame receiver.
// Used by every module under rtl/core except trfr_ram; depends on nothing.
package trfr_pkg;

    localparam int MAX_PAYLOAD   = 16;
    localparam int SIZE_W        = 5;
    localparam int PAYLOAD_DEPTH = 2 * MAX_PAYLOAD;
    localparam int PAYLOAD_AW    = $clog2(PAYLOAD_DEPTH);
    localparam int QUEUE_DEPTH   = 2;
    localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] START_BYTE = 8'hAA;
    localparam logic [7:0] BROADCAST  = 8'h00;

    localparam logic [2:0] KIND_FWD   = 3'd0;
    localparam logic [2:0] KIND_DELIV = 3'd1;
    localparam logic [2:0] KIND_EMPTY = 3'd2;
    localparam logic [2:0] KIND_CKERR = 3'd3;
    localparam logic [2:0] KIND_OVER  = 3'd4;

    typedef enum logic [1:0] {
        JOB_FRAME,
        JOB_CKERR,
        JOB_OVER
    } job_kind_t;

    typedef struct packed {
        job_kind_t         jkind;
        logic              fwd;
        logic              deliv;
        logic              uses_bank;
        logic              bank;
        logic [7:0]        src;
        logic [7:0]        dst;
        logic [SIZE_W-1:0] size;
        logic [7:0]        chk;
    } job_t;

    typedef struct packed {
        logic valid;
        logic bank;
    } release_t;

    // payload buffer is split in two banks of MAX_PAYLOAD bytes
    function automatic logic [PAYLOAD_AW-1:0] payload_addr(input logic bank,
                                                           input logic [SIZE_W-1:0] idx);
        logic [PAYLOAD_AW-1:0] base;
        base = bank ? PAYLOAD_AW'(MAX_PAYLOAD) : '0;
        return PAYLOAD_AW'(idx) + base;
    endfunction

endpackage

// ===== rtl/core/token_ring_frame_receiver_core.sv =====
// Ring node frame receiver, top level.
// Input: one received byte per transaction on in_valid/in_stall/rx_byte.
// Output: results on out_valid/out_stall with kind, out_byte, sender, last;
//   last marks the final result caused by one input byte.
// Config: cfg_valid/cfg_ready writes device_address (always ready); write only when idle.
// The parser takes one byte per cycle while in_stall is low. A checksum byte (or an
// oversized size byte) may queue a job (two deep) for the replay sequencer, which emits
// one status result per job, or a forwarded frame and/or delivered payload. Header,
// checksum, status and empty-delivery results come straight from the job; each payload
// byte takes a read state for the registered read of the payload RAM, then an emit state.
// The payload RAM holds two banks; a new frame's payload byte is stalled only while
// its bank is still queued or being replayed, and the size or checksum byte stalls while the
// job queue is full. When the output is stalled the result is held in the output
// register and the sequencer waits. Reset returns to idle (waiting for start byte
// 0xAA), empties the queue and sets the address to 1; no clearing pass is needed.
// Depends on trfr_pkg, trfr_front, trfr_job_queue, trfr_back, trfr_ram.
module token_ring_frame_receiver_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] kind,
    output logic [7:0] out_byte,
    output logic [7:0] sender,
    output logic       last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [6:0] device_address
);

    logic                            q_full;
    logic                            q_not_empty;
    logic                            push;
    logic                            pop;
    trfr_pkg::job_t                  push_job;
    trfr_pkg::job_t                  q_head;
    trfr_pkg::release_t              rel;
    logic                            ram_we;
    logic [trfr_pkg::PAYLOAD_AW-1:0] ram_waddr;
    logic [7:0]                      ram_wdata;
    logic                            ram_re;
    logic [trfr_pkg::PAYLOAD_AW-1:0] ram_raddr;
    logic [7:0]                      ram_rdata;

    trfr_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .device_address (device_address),
        .q_full         (q_full),
        .push           (push),
        .push_job       (push_job),
        .rel            (rel),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_wdata      (ram_wdata)
    );

    trfr_job_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    trfr_ram #(
        .WIDTH (8),
        .DEPTH (trfr_pkg::PAYLOAD_DEPTH)
    ) u_payload_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    trfr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .pop         (pop),
        .rel         (rel),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .out_byte    (out_byte),
        .sender      (sender),
        .last        (last)
    );

endmodule

// ===== rtl/core/trfr_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module trfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/trfr_front.sv =====
// Front end: frame parser, checksum, address register and payload bank control.
// Depends on trfr_pkg; writes the payload RAM and pushes jobs into trfr_job_queue.
module trfr_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      rx_byte,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [6:0]                      device_address,
    input  logic                            q_full,
    output logic                            push,
    output trfr_pkg::job_t                  push_job,
    input  trfr_pkg::release_t              rel,
    output logic                            ram_we,
    output logic [trfr_pkg::PAYLOAD_AW-1:0] ram_waddr,
    output logic [7:0]                      ram_wdata
);

    typedef enum logic [2:0] {
        P_IDLE,
        P_SRC,
        P_DST,
        P_SIZE,
        P_DATA,
        P_CHK
    } phase_t;

    phase_t                      phase_reg, phase_next;
    logic [7:0]                  src_reg, src_next;
    logic [7:0]                  dst_reg, dst_next;
    logic [trfr_pkg::SIZE_W-1:0] size_reg, size_next;
    logic [trfr_pkg::SIZE_W-1:0] fill_reg, fill_next;
    logic [7:0]                  csum_reg, csum_next;
    logic                        bank_reg, bank_next;
    logic [1:0]                  busy_reg, busy_next;
    logic [6:0]                  addr_reg;

    logic       accept;
    logic [7:0] my_addr;
    logic       is_fwd;
    logic       is_deliv;

    assign cfg_ready = 1'b1;
    assign in_stall  = ((phase_reg == P_DATA) && busy_reg[bank_reg])
                     || (((phase_reg == P_SIZE) || (phase_reg == P_CHK)) && q_full);
    assign accept    = in_valid && !in_stall;

    assign my_addr  = {1'b0, addr_reg};
    assign is_fwd   = (src_reg != my_addr) && (dst_reg != my_addr);
    assign is_deliv = (dst_reg == trfr_pkg::BROADCAST) || (dst_reg == my_addr);

    assign ram_we    = accept && (phase_reg == P_DATA);
    assign ram_waddr = trfr_pkg::payload_addr(bank_reg, fill_reg);
    assign ram_wdata = rx_byte;

    always_comb
    begin
        phase_next = phase_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        size_next  = size_reg;
        fill_next  = fill_reg;
        csum_next  = csum_reg;
        bank_next  = bank_reg;
        busy_next  = busy_reg;
        push       = 1'b0;
        push_job   = '0;
        push_job.src   = src_reg;
        push_job.dst   = dst_reg;
        push_job.size  = size_reg;
        push_job.chk   = rx_byte;
        push_job.bank  = bank_reg;
        push_job.jkind = trfr_pkg::JOB_FRAME;

        if (rel.valid)
        begin
            busy_next[rel.bank] = 1'b0;
        end

        if (accept)
        begin
            case (phase_reg)
                P_SRC:
                begin
                    src_next   = rx_byte;
                    csum_next  = rx_byte;
                    phase_next = P_DST;
                end
                P_DST:
                begin
                    dst_next   = rx_byte;
                    csum_next  = csum_reg ^ rx_byte;
                    phase_next = P_SIZE;
                end
                P_SIZE:
                begin
                    csum_next = csum_reg ^ rx_byte;
                    size_next = rx_byte[trfr_pkg::SIZE_W-1:0];
                    fill_next = '0;
                    if (rx_byte > 8'(trfr_pkg::MAX_PAYLOAD))
                    begin
                        push           = 1'b1;
                        push_job.jkind = trfr_pkg::JOB_OVER;
                        phase_next     = P_IDLE;
                    end
                    else if (rx_byte == 8'd0)
                    begin
                        phase_next = P_CHK;
                    end
                    else
                    begin
                        phase_next = P_DATA;
                    end
                end
                P_DATA:
                begin
                    csum_next = csum_reg ^ rx_byte;
                    fill_next = fill_reg + 1'b1;
                    if (fill_next >= size_reg)
                    begin
                        phase_next = P_CHK;
                    end
                end
                P_CHK:
                begin
                    phase_next = P_IDLE;
                    if (rx_byte != csum_reg)
                    begin
                        push           = 1'b1;
                        push_job.jkind = trfr_pkg::JOB_CKERR;
                    end
                    else if (is_fwd || is_deliv)
                    begin
                        push               = 1'b1;
                        push_job.fwd       = is_fwd;
                        push_job.deliv     = is_deliv;
                        push_job.uses_bank = (size_reg != '0);
                        if (size_reg != '0)
                        begin
                            // bank stays owned by the back end until its replay ends
                            busy_next[bank_reg] = 1'b1;
                            bank_next           = !bank_reg;
                        end
                    end
                end
                default:
                begin
                    if (rx_byte == trfr_pkg::START_BYTE)
                    begin
                        phase_next = P_SRC;
                        fill_next  = '0;
                        csum_next  = '0;
                    end
                    else
                    begin
                        phase_next = P_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            src_reg   <= '0;
            dst_reg   <= '0;
            size_reg  <= '0;
            fill_reg  <= '0;
            csum_reg  <= '0;
            bank_reg  <= 1'b0;
            busy_reg  <= '0;
            addr_reg  <= 7'd1;
        end
        else
        begin
            phase_reg <= phase_next;
            src_reg   <= src_next;
            dst_reg   <= dst_next;
            size_reg  <= size_next;
            fill_reg  <= fill_next;
            csum_reg  <= csum_next;
            bank_reg  <= bank_next;
            busy_reg  <= busy_next;
            if (cfg_valid && cfg_ready)
            begin
                addr_reg <= device_address;
            end
        end
    end

endmodule

// ===== rtl/core/trfr_job_queue.sv =====
// Short FIFO of frame jobs between parser and replay sequencer.
// Depends on trfr_pkg for the job type and depth.
module trfr_job_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  trfr_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output trfr_pkg::job_t head
);

    trfr_pkg::job_t                   slot_reg [trfr_pkg::QUEUE_DEPTH];
    logic [trfr_pkg::QUEUE_PTR_W-1:0] wptr_reg, wptr_next;
    logic [trfr_pkg::QUEUE_PTR_W-1:0] rptr_reg, rptr_next;
    logic [trfr_pkg::QUEUE_CNT_W-1:0] cnt_reg, cnt_next;

    localparam logic [trfr_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
        trfr_pkg::QUEUE_PTR_W'(trfr_pkg::QUEUE_DEPTH - 1);

    assign full      = (cnt_reg == trfr_pkg::QUEUE_CNT_W'(trfr_pkg::QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = slot_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == PTR_LAST) ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == PTR_LAST) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// ===== rtl/core/trfr_back.sv =====
// Back end: replays, delivers or reports status, one result per step, into the output register.
// Depends on trfr_pkg; reads the payload RAM and releases banks to trfr_front.
module trfr_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_not_empty,
    input  trfr_pkg::job_t                  q_head,
    output logic                            pop,
    output trfr_pkg::release_t              rel,
    output logic                            ram_re,
    output logic [trfr_pkg::PAYLOAD_AW-1:0] ram_raddr,
    input  logic [7:0]                      ram_rdata,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [2:0]                      kind,
    output logic [7:0]                      out_byte,
    output logic [7:0]                      sender,
    output logic                            last
);

    typedef enum logic [3:0] {
        B_IDLE,
        B_HDR,
        B_FRD,
        B_FEMIT,
        B_FCHK,
        B_DRD,
        B_DEMIT,
        B_DEMPTY,
        B_STAT
    } bstate_t;

    bstate_t                     state_reg, state_next;
    trfr_pkg::job_t              job_reg, job_next;
    logic [trfr_pkg::SIZE_W-1:0] idx_reg, idx_next;
    logic                        ov_reg, ov_next;
    logic [2:0]                  kind_reg, kind_next;
    logic [7:0]                  byte_reg, byte_next;
    logic [7:0]                  sender_reg, sender_next;
    logic                        last_reg, last_next;

    logic out_free;
    logic at_end;

    assign out_free  = !ov_reg || !out_stall;
    assign at_end    = (idx_reg == job_reg.size - 1'b1);
    assign ram_raddr = trfr_pkg::payload_addr(job_reg.bank, idx_reg);
    assign ram_re    = (state_reg == B_FRD) || (state_reg == B_DRD);

    assign out_valid = ov_reg;
    assign kind      = kind_reg;
    assign out_byte  = byte_reg;
    assign sender    = sender_reg;
    assign last      = last_reg;

    always_comb
    begin
        state_next  = state_reg;
        job_next    = job_reg;
        idx_next    = idx_reg;
        ov_next     = ov_reg && out_stall;
        kind_next   = kind_reg;
        byte_next   = byte_reg;
        sender_next = sender_reg;
        last_next   = last_reg;
        pop         = 1'b0;
        rel         = '0;

        case (state_reg)
            B_IDLE:
            begin
                if (q_not_empty)
                begin
                    pop      = 1'b1;
                    job_next = q_head;
                    idx_next = '0;
                    if (q_head.jkind != trfr_pkg::JOB_FRAME)
                    begin
                        state_next = B_STAT;
                    end
                    else if (q_head.fwd)
                    begin
                        state_next = B_HDR;
                    end
                    else if (q_head.size == '0)
                    begin
                        state_next = B_DEMPTY;
                    end
                    else
                    begin
                        state_next = B_DRD;
                    end
                end
            end
            B_HDR:
            begin
                if (out_free)
                begin
                    ov_next     = 1'b1;
                    kind_next   = trfr_pkg::KIND_FWD;
                    sender_next = job_reg.src;
                    last_next   = 1'b0;
                    case (idx_reg[1:0])
                        2'd0:    byte_next = trfr_pkg::START_BYTE;
                        2'd1:    byte_next = job_reg.src;
                        2'd2:    byte_next = job_reg.dst;
                        default: byte_next = 8'(job_reg.size);
                    endcase
                    if (idx_reg[1:0] == 2'd3)
                    begin
                        idx_next   = '0;
                        state_next = (job_reg.size == '0) ? B_FCHK : B_FRD;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            B_FRD:
            begin
                state_next = B_FEMIT;
            end
            B_FEMIT:
            begin
                if (out_free)
                begin
                    ov_next     = 1'b1;
                    kind_next   = trfr_pkg::KIND_FWD;
                    byte_next   = ram_rdata;
                    sender_next = job_reg.src;
                    last_next   = 1'b0;
                    if (at_end)
                    begin
                        state_next = B_FCHK;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = B_FRD;
                    end
                end
            end
            B_FCHK:
            begin
                if (out_free)
                begin
                    ov_next     = 1'b1;
                    kind_next   = trfr_pkg::KIND_FWD;
                    byte_next   = job_reg.chk;
                    sender_next = job_reg.src;
                    last_next   = !job_reg.deliv;
                    idx_next    = '0;
                    if (!job_reg.deliv)
                    begin
                        rel.valid  = job_reg.uses_bank;
                        rel.bank   = job_reg.bank;
                        state_next = B_IDLE;
                    end
                    else if (job_reg.size == '0)
                    begin
                        state_next = B_DEMPTY;
                    end
                    else
                    begin
                        state_next = B_DRD;
                    end
                end
            end
            B_DRD:
            begin
                state_next = B_DEMIT;
            end
            B_DEMIT:
            begin
                if (out_free)
                begin
                    ov_next     = 1'b1;
                    kind_next   = trfr_pkg::KIND_DELIV;
                    byte_next   = ram_rdata;
                    sender_next = job_reg.src;
                    last_next   = at_end;
                    if (at_end)
                    begin
                        rel.valid  = job_reg.uses_bank;
                        rel.bank   = job_reg.bank;
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = B_DRD;
                    end
                end
            end
            B_DEMPTY:
            begin
                if (out_free)
                begin
                    ov_next     = 1'b1;
                    kind_next   = trfr_pkg::KIND_EMPTY;
                    byte_next   = '0;
                    sender_next = job_reg.src;
                    last_next   = 1'b1;
                    state_next  = B_IDLE;
                end
            end
            B_STAT:
            begin
                if (out_free)
                begin
                    ov_next     = 1'b1;
                    kind_next   = (job_reg.jkind == trfr_pkg::JOB_OVER)
                                ? trfr_pkg::KIND_OVER : trfr_pkg::KIND_CKERR;
                    byte_next   = '0;
                    sender_next = job_reg.src;
                    last_next   = 1'b1;
                    state_next  = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            ov_reg     <= 1'b0;
            job_reg    <= '0;
            idx_reg    <= '0;
            kind_reg   <= '0;
            byte_reg   <= '0;
            sender_reg <= '0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ov_reg     <= ov_next;
            job_reg    <= job_next;
            idx_reg    <= idx_next;
            kind_reg   <= kind_next;
            byte_reg   <= byte_next;
            sender_reg <= sender_next;
            last_reg   <= last_next;
        end
    end

endmodule

// ===== sim/tb_token_ring_frame_receiver_core.sv =====
// Testbench for token_ring_frame_receiver_core: feeds ring frames and noise byte by byte,
// predicts forwarded/delivered/status results and checks them in order.
// Depends on trfr_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_token_ring_frame_receiver_core;

    localparam int QUIET_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 150;

    typedef enum logic [2:0] {
        RX_IDLE,
        RX_SRC,
        RX_DST,
        RX_SIZE,
        RX_DATA,
        RX_CHK
    } rx_state_t;

    typedef struct {
        logic [2:0] kind;
        logic [7:0] data;
        logic [7:0] src;
        logic       last;
    } ring_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [2:0] kind;
    logic [7:0] out_byte;
    logic [7:0] sender;
    logic       last;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [6:0] device_address = 7'd0;

    // receiver shadow state
    rx_state_t  rx_state = RX_IDLE;
    logic [6:0] node_addr = 7'd1;
    logic [7:0] f_src = 8'h00;
    logic [7:0] f_dst = 8'h00;
    logic [4:0] f_size = 5'd0;
    logic [4:0] f_fill = 5'd0;
    logic [7:0] f_sum = 8'h00;
    logic [7:0] f_payload [trfr_pkg::MAX_PAYLOAD];

    logic [7:0]   link_bytes [$];
    ring_result_t pending_results [$];
    ring_result_t want;

    int  bytes_queued = 0;
    int  bytes_taken = 0;
    int  results_checked = 0;
    int  addr_writes = 0;
    int  errors = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  quiet = 0;
    bit  idle_on = 1'b1;
    bit  stall_on = 1'b1;

    token_ring_frame_receiver_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .out_byte       (out_byte),
        .sender         (sender),
        .last           (last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .device_address (device_address)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic ring_result_t frame_result(input logic [2:0] k, input logic [7:0] d);
        ring_result_t r;
        r.kind = k;
        r.data = d;
        r.src  = f_src;
        r.last = 1'b0;
        return r;
    endfunction

    // Advance the shadow receiver by one accepted byte and queue what it emits.
    task automatic advance_receiver(input logic [7:0] b);
        ring_result_t res [$];
        logic [7:0]   addr8;
        int           i;
        addr8 = {1'b0, node_addr};
        case (rx_state)
            RX_SRC:
            begin
                f_src = b;
                f_sum = b;
                rx_state = RX_DST;
            end
            RX_DST:
            begin
                f_dst = b;
                f_sum ^= b;
                rx_state = RX_SIZE;
            end
            RX_SIZE:
            begin
                f_sum ^= b;
                f_size = b[4:0];
                if (b > trfr_pkg::MAX_PAYLOAD)
                begin
                    res.push_back(frame_result(trfr_pkg::KIND_OVER, 8'h00));
                    rx_state = RX_IDLE;
                end
                else
                begin
                    f_fill = 5'd0;
                    rx_state = (b == 8'h00) ? RX_CHK : RX_DATA;
                end
            end
            RX_DATA:
            begin
                if (f_fill < trfr_pkg::MAX_PAYLOAD)
                    f_payload[f_fill] = b;
                f_sum ^= b;
                f_fill = f_fill + 5'd1;
                if (f_fill >= f_size)
                    rx_state = RX_CHK;
            end
            RX_CHK:
            begin
                if (b != f_sum)
                    res.push_back(frame_result(trfr_pkg::KIND_CKERR, 8'h00));
                else
                begin
                    if (f_src != addr8 && f_dst != addr8)
                    begin
                        res.push_back(frame_result(trfr_pkg::KIND_FWD, trfr_pkg::START_BYTE));
                        res.push_back(frame_result(trfr_pkg::KIND_FWD, f_src));
                        res.push_back(frame_result(trfr_pkg::KIND_FWD, f_dst));
                        res.push_back(frame_result(trfr_pkg::KIND_FWD, {3'b000, f_size}));
                        for (i = 0; i < f_size; i++)
                            res.push_back(frame_result(trfr_pkg::KIND_FWD, f_payload[i]));
                        res.push_back(frame_result(trfr_pkg::KIND_FWD, b));
                    end
                    if (f_dst == trfr_pkg::BROADCAST || f_dst == addr8)
                    begin
                        if (f_size == 5'd0)
                            res.push_back(frame_result(trfr_pkg::KIND_EMPTY, 8'h00));
                        for (i = 0; i < f_size; i++)
                            res.push_back(frame_result(trfr_pkg::KIND_DELIV, f_payload[i]));
                    end
                end
                rx_state = RX_IDLE;
            end
            default:
            begin
                if (b == trfr_pkg::START_BYTE)
                begin
                    rx_state = RX_SRC;
                    f_fill = 5'd0;
                    f_sum = 8'h00;
                end
                else
                    rx_state = RX_IDLE;
            end
        endcase
        if (res.size() > 0)
            res[res.size() - 1].last = 1'b1;
        foreach (res[n])
            pending_results.push_back(res[n]);
    endtask

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            rx_byte <= 8'h00;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                advance_receiver(rx_byte);
                bytes_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (idle_on && $urandom_range(0, 5) == 0)
                begin
                    gap_left = $urandom_range(0, 9);
                    in_valid <= 1'b0;
                end
                else if (link_bytes.size() > 0)
                begin
                    in_valid <= 1'b1;
                    rx_byte <= link_bytes.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_checked++;
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result: kind %0d, out_byte %02h, sender %02h, last %0b",
                           kind, out_byte, sender, last);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (kind !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, kind);
                        errors++;
                    end
                    if (out_byte !== want.data)
                    begin
                        $error("out_byte: expected %02h, got %02h", want.data, out_byte);
                        errors++;
                    end
                    if (sender !== want.src)
                    begin
                        $error("sender: expected %02h, got %02h", want.src, sender);
                        errors++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, last);
                        errors++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (stall_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 9);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // watchdog: counts cycles without any transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("timeout: %0d results still outstanding", pending_results.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic push_byte(input logic [7:0] b);
        link_bytes.push_back(b);
        bytes_queued++;
    endtask

    // fill < 0 gives random payload bytes, otherwise every payload byte is fill
    task automatic send_frame(input logic [7:0] src, input logic [7:0] dst,
                              input logic [7:0] size, input bit bad_sum, input int fill);
        logic [7:0] sum;
        logic [7:0] d;
        int         i;
        push_byte(trfr_pkg::START_BYTE);
        push_byte(src);
        push_byte(dst);
        push_byte(size);
        sum = src ^ dst ^ size;
        if (size > trfr_pkg::MAX_PAYLOAD)
            return;
        for (i = 0; i < size; i++)
        begin
            d = (fill < 0) ? 8'($urandom) : 8'(fill);
            push_byte(d);
            sum ^= d;
        end
        if (bad_sum)
            sum ^= 8'($urandom_range(1, 255));
        push_byte(sum);
    endtask

    function automatic logic [7:0] pick_addr();
        case ($urandom_range(0, 5))
            0: return {1'b0, node_addr};
            1: return trfr_pkg::BROADCAST;
            2: return {1'b1, node_addr};
            3: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_size();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return 8'($urandom_range(trfr_pkg::MAX_PAYLOAD + 1, 255));
        else if (r == 1)
            return 8'(trfr_pkg::MAX_PAYLOAD);
        else if (r < 4)
            return 8'($urandom_range(5, trfr_pkg::MAX_PAYLOAD - 1));
        else
            return 8'($urandom_range(0, 4));
    endfunction

    // mostly well-formed frames, some stray bytes and cut-off frames
    task automatic random_traffic(input int budget);
        int         start_cnt;
        int         r;
        int         k;
        logic [7:0] size;
        start_cnt = bytes_queued;
        while (bytes_queued - start_cnt < budget)
        begin
            r = $urandom_range(0, 19);
            size = pick_size();
            if (r == 0)
                push_byte(8'($urandom));
            else if (r == 1 && size > 0 && size <= trfr_pkg::MAX_PAYLOAD)
            begin
                // cut off mid payload: the next frame is taken as data
                push_byte(trfr_pkg::START_BYTE);
                push_byte(pick_addr());
                push_byte(pick_addr());
                push_byte(size);
                k = $urandom_range(0, size - 1);
                repeat (k)
                    push_byte(8'($urandom));
            end
            else
                send_frame(pick_addr(), pick_addr(), size, $urandom_range(0, 7) == 0, -1);
        end
    endtask

    // wait until every byte is taken and every result is in; close any open frame
    task automatic settle();
        do
        begin
            while (bytes_taken != bytes_queued)
                @(posedge clk);
            if (rx_state != RX_IDLE)
                push_byte(8'h00);
        end
        while (bytes_taken != bytes_queued || rx_state != RX_IDLE);
        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic set_address(input logic [6:0] a);
        @(posedge clk);
        cfg_valid <= 1'b1;
        device_address <= a;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        node_addr = a;
        addr_writes++;
    endtask

    initial
    begin
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;

        // directed frames at the reset address
        push_byte(8'h00);
        push_byte(8'hFF);
        send_frame(8'hFF, trfr_pkg::BROADCAST, 8'd1, 1'b0, trfr_pkg::START_BYTE);
        send_frame(8'h80, 8'h01, 8'd0, 1'b0, -1);
        send_frame(8'h02, 8'h03, 8'd0, 1'b1, -1);
        send_frame(8'h05, 8'h06, 8'(trfr_pkg::MAX_PAYLOAD + 1), 1'b0, -1);
        send_frame(8'h01, 8'h05, 8'd0, 1'b0, -1);
        settle();

        set_address(7'd0);
        random_traffic(16);
        settle();

        set_address(7'd127);
        random_traffic(16);
        settle();

        set_address(7'($urandom));
        random_traffic(16);
        settle();

        idle_on = 1'b0;
        stall_on = 1'b0;
        set_address(7'($urandom));
        random_traffic(16);
        settle();

        $display("run covered %0d link bytes and %0d results over %0d address settings",
                 bytes_taken, results_checked, addr_writes + 1);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/trfr_pkg.sv
rtl/core/trfr_ram.sv
rtl/core/trfr_front.sv
rtl/core/trfr_job_queue.sv
rtl/core/trfr_back.sv
rtl/core/token_ring_frame_receiver_core.sv
sim/tb_token_ring_frame_receiver_core.sv
